### sv/fpb_pkg.sv
// Shared types, constants and helpers for the framebuffer pixel blend block.
package fpb_pkg;

   localparam int CH_BITS = 16;
   localparam int PIX_BITS = 4 * CH_BITS;
   localparam logic [CH_BITS-1:0] CH_ONE = CH_BITS'(1) << (CH_BITS - 1);

   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH       = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLEND_MODE  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLEAR_RED   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLEAR_GREEN = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLEAR_BLUE  = 3'd5;

   localparam logic MODE_ADD     = 1'b0;
   localparam logic MODE_REPLACE = 1'b1;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         pos_x;
      logic [7:0]         pos_y;
      logic [CH_BITS-1:0] src_red;
      logic [CH_BITS-1:0] src_green;
      logic [CH_BITS-1:0] src_blue;
      logic [CH_BITS-1:0] src_alpha;
   } fpb_req_type;

   typedef struct packed {
      logic [CH_BITS-1:0] out_red;
      logic [CH_BITS-1:0] out_green;
      logic [CH_BITS-1:0] out_blue;
      logic [CH_BITS-1:0] out_alpha;
      logic               in_range;
   } fpb_rsp_type;

   typedef struct packed {
      logic [8:0]         canvas_width;
      logic [8:0]         canvas_height;
      logic               blend_mode;
      logic [CH_BITS-1:0] clear_red;
      logic [CH_BITS-1:0] clear_green;
      logic [CH_BITS-1:0] clear_blue;
   } fpb_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MULT,
      ST_WRITE,
      ST_CLEAR
   } fpb_state_type;

   typedef struct packed {
      logic load;
      logic rd;
      logic mul;
      logic clr;
      logic wb;
   } fpb_cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       pix_ok;
      logic       clr_last;
   } fpb_status_type;

   function automatic logic [CH_BITS-1:0] sat_one(input logic [CH_BITS+1:0] v);
      sat_one = (v > (CH_BITS+2)'(CH_ONE)) ? CH_ONE : v[CH_BITS-1:0];
   endfunction

endpackage

### sv/fpb_ctrl.sv
// Sequencing state machine for draw, read and clear beats.
module fpb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  fpb_pkg::fpb_status_type status,
   output fpb_pkg::fpb_cmd_type    cmd
);

   fpb_pkg::fpb_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpb_pkg::ST_IDLE: begin
            if (start) begin
               if (status.opcode == fpb_pkg::OP_CLEAR) begin
                  state_in = fpb_pkg::ST_CLEAR;
               end else if (status.pix_ok) begin
                  state_in = fpb_pkg::ST_READ;
               end else begin
                  state_in = fpb_pkg::ST_WRITE;
               end
            end
         end
         fpb_pkg::ST_READ:  state_in = fpb_pkg::ST_MULT;
         fpb_pkg::ST_MULT:  state_in = fpb_pkg::ST_WRITE;
         fpb_pkg::ST_WRITE: state_in = fpb_pkg::ST_IDLE;
         fpb_pkg::ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = fpb_pkg::ST_WRITE;
            end
         end
         default: state_in = fpb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         fpb_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         fpb_pkg::ST_READ:  cmd.rd  = 1'b1;
         fpb_pkg::ST_MULT:  cmd.mul = 1'b1;
         fpb_pkg::ST_WRITE: cmd.wb  = 1'b1;
         fpb_pkg::ST_CLEAR: cmd.clr = 1'b1;
         default:           busy    = 1'b1;
      endcase
   end

endmodule

### sv/fpb_datapath.sv
// Pixel memory, blend multipliers, clear sweep counter and result register.
module fpb_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fpb_pkg::fpb_req_type    req_payload,
   input  fpb_pkg::fpb_cfg_type    cfg,
   input  fpb_pkg::fpb_cmd_type    cmd,
   output fpb_pkg::fpb_status_type status,
   output logic                   rsp_strobe,
   output fpb_pkg::fpb_rsp_type    rsp_payload
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam int CB = fpb_pkg::CH_BITS;

   logic [fpb_pkg::PIX_BITS-1:0] mem [DEPTH];

   fpb_pkg::fpb_req_type          req_ff;
   logic                          ok_ff;
   logic [AW-1:0]                 addr_ff, addr_in;
   logic [AW-1:0]                 clr_cnt_ff, clr_cnt_in;
   logic [fpb_pkg::PIX_BITS-1:0]  rdata_ff;
   logic [2*CB-1:0]               prod_ff [4];
   logic [2*CB-1:0]               prod_in [4];
   logic                          rsp_strobe_ff;
   fpb_pkg::fpb_rsp_type           rsp_payload_ff, rsp_payload_in;

   logic [31:0]                   addr_full;
   logic                          req_range;
   logic                          req_ok;
   logic [CB-1:0]                 src_sat [4];
   logic [CB-1:0]                 old_ch [4];
   logic [CB-1:0]                 inv_alpha;
   logic [CB+1:0]                 sum [4];
   logic [fpb_pkg::PIX_BITS-1:0]  blend_pix;
   logic [fpb_pkg::PIX_BITS-1:0]  new_pix;
   logic [fpb_pkg::PIX_BITS-1:0]  clear_pix;
   logic [fpb_pkg::PIX_BITS-1:0]  res_pix;
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [fpb_pkg::PIX_BITS-1:0]  mem_wdata;

   // Decode of the incoming beat
   always_comb begin
      addr_full = 32'(req_payload.pos_y) * 32'(MAX_WIDTH) + 32'(req_payload.pos_x);
      addr_in   = addr_full[AW-1:0];
      req_range = ({1'b0, req_payload.pos_x} < cfg.canvas_width)
               && ({1'b0, req_payload.pos_y} < cfg.canvas_height)
               && (32'(req_payload.pos_x) < 32'(MAX_WIDTH))
               && (32'(req_payload.pos_y) < 32'(MAX_HEIGHT));
      req_ok    = req_range && ((req_payload.opcode == fpb_pkg::OP_DRAW)
                             || (req_payload.opcode == fpb_pkg::OP_READ));
      status.opcode   = req_payload.opcode;
      status.pix_ok   = req_ok;
      status.clr_last = (clr_cnt_ff == LAST_ADDR);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_payload;
         ok_ff   <= req_ok;
         addr_ff <= addr_in;
      end
   end

   // Clear sweep address
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (cmd.load) begin
         clr_cnt_in = '0;
      end else if (cmd.clr && !status.clr_last) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Per-channel arithmetic; channel 0 red .. 3 alpha, red in the top bits
   always_comb begin
      src_sat[0] = fpb_pkg::sat_one({2'b00, req_ff.src_red});
      src_sat[1] = fpb_pkg::sat_one({2'b00, req_ff.src_green});
      src_sat[2] = fpb_pkg::sat_one({2'b00, req_ff.src_blue});
      src_sat[3] = fpb_pkg::sat_one({2'b00, req_ff.src_alpha});
      inv_alpha  = fpb_pkg::CH_ONE - src_sat[3];
      for (int c = 0; c < 4; c++) begin
         old_ch[c]  = rdata_ff[(3-c)*CB +: CB];
         prod_in[c] = (2*CB)'(old_ch[c]) * (2*CB)'(inv_alpha);
         sum[c]     = {2'b00, src_sat[c]} + (CB+2)'(prod_ff[c][2*CB-1:CB-1]);
      end
      blend_pix = {fpb_pkg::sat_one(sum[0]), fpb_pkg::sat_one(sum[1]),
                   fpb_pkg::sat_one(sum[2]), sum[3][CB-1:0]};
      new_pix   = (cfg.blend_mode == fpb_pkg::MODE_REPLACE)
                ? {src_sat[0], src_sat[1], src_sat[2], src_sat[3]} : blend_pix;
      clear_pix = {fpb_pkg::sat_one({2'b00, cfg.clear_red}),
                   fpb_pkg::sat_one({2'b00, cfg.clear_green}),
                   fpb_pkg::sat_one({2'b00, cfg.clear_blue}),
                   fpb_pkg::CH_ONE};
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         for (int c = 0; c < 4; c++) begin
            prod_ff[c] <= prod_in[c];
         end
      end
   end

   // Pixel memory
   always_comb begin
      mem_we    = cmd.clr || (cmd.wb && ok_ff && (req_ff.opcode == fpb_pkg::OP_DRAW));
      mem_waddr = cmd.clr ? clr_cnt_ff : addr_ff;
      mem_wdata = cmd.clr ? clear_pix : new_pix;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   // Result beat
   always_comb begin
      res_pix = '0;
      rsp_payload_in = '0;
      case (req_ff.opcode)
         fpb_pkg::OP_CLEAR: res_pix = clear_pix;
         fpb_pkg::OP_DRAW:  res_pix = ok_ff ? new_pix : '0;
         fpb_pkg::OP_READ:  res_pix = ok_ff ? rdata_ff : '0;
         default:           res_pix = '0;
      endcase
      rsp_payload_in.out_red   = res_pix[3*CB +: CB];
      rsp_payload_in.out_green = res_pix[2*CB +: CB];
      rsp_payload_in.out_blue  = res_pix[CB +: CB];
      rsp_payload_in.out_alpha = res_pix[0 +: CB];
      rsp_payload_in.in_range  = ok_ff || (req_ff.opcode == fpb_pkg::OP_CLEAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.wb;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wb) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### sv/framebuffer_pixel_blend.sv
// Top level of the framebuffer pixel blend block: CSRs, controller and datapath.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ---------------------------
//  request  start, busy, req_payload                beat taken when start && !busy
//  result   rsp_strobe, rsp_payload                 one cycle per beat, no stall
//  csr      csr_we, csr_index, csr_wdata            write when csr_we, no wait
//
// In-range draw and read step through memory read, multiply and write back; an
// out-of-range or unused opcode goes straight to write back. Clear writes all
// MAX_WIDTH*MAX_HEIGHT pixels, one per cycle through the single memory write port.
// The result shows on the cycle after the beat's last cycle; the next beat may be
// taken in that same cycle. Reset clears control, sets the canvas to 256x256 and
// the other CSRs to zero; pixel memory holds no value until cleared or drawn.
module framebuffer_pixel_blend #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  fpb_pkg::fpb_req_type                     req_payload,
   output logic                                    rsp_strobe,
   output fpb_pkg::fpb_rsp_type                     rsp_payload,
   input  logic                                    csr_we,
   input  logic [fpb_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [fpb_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);

   fpb_pkg::fpb_cfg_type    cfg_ff, cfg_in;
   fpb_pkg::fpb_cmd_type    cmd;
   fpb_pkg::fpb_status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            fpb_pkg::CSR_WIDTH:       cfg_in.canvas_width  = csr_wdata[8:0];
            fpb_pkg::CSR_HEIGHT:      cfg_in.canvas_height = csr_wdata[8:0];
            fpb_pkg::CSR_BLEND_MODE:  cfg_in.blend_mode    = csr_wdata[0];
            fpb_pkg::CSR_CLEAR_RED:   cfg_in.clear_red     = csr_wdata;
            fpb_pkg::CSR_CLEAR_GREEN: cfg_in.clear_green   = csr_wdata;
            fpb_pkg::CSR_CLEAR_BLUE:  cfg_in.clear_blue    = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canvas_width  <= 9'd256;
         cfg_ff.canvas_height <= 9'd256;
         cfg_ff.blend_mode    <= fpb_pkg::MODE_ADD;
         cfg_ff.clear_red     <= '0;
         cfg_ff.clear_green   <= '0;
         cfg_ff.clear_blue    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fpb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   fpb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
